// ----- src/gwr_pkg.sv -----
`default_nettype none

package gwr_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_CUTOFF = 2'd0;
	localparam logic [1:0] REG_SHIFT  = 2'd1;

	// Register reset values: 2019-04-06 and 1024 weeks
	localparam logic [15:0] CUTOFF_RESET = 16'd17992;
	localparam logic [13:0] SHIFT_RESET  = 14'd7168;

	// Day number of 2000-03-01, counted from 1970-01-01
	localparam logic [15:0] MAR_2000_DAY = 16'd11017;
	localparam logic [11:0] BASE_YEAR    = 12'd2000;

	// Year estimate: w * YEAR_RECIP >> RECIP_SHIFT approximates w / 365.2425
	localparam logic [11:0] YEAR_RECIP  = 12'd2871;
	localparam int          RECIP_SHIFT = 20;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	// Day number after the shift, relative to 2000-03-01, plus the raw date
	typedef struct packed {
		logic               shifted;
		logic signed [17:0] w;
		date_t              raw;
	} day_num_t;

	// Day of the March-based year on which month mp starts
	function automatic logic [8:0] month_offset(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Days from 2000-03-01 to March 1 of year e of the era
	function automatic logic [15:0] year_start(input logic [7:0] e);
		logic [16:0] acc;
		acc = {9'd0, e} * 17'd365;
		acc = acc + {11'd0, e[7:2]};
		if (e >= 8'd100) begin
			acc = acc - 17'd1;
		end
		return acc[15:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/gps_week_rollover_date_fix.sv -----
// GPS week rollover date fix.
// A receiver date (two-digit year meaning 20xx, month, day) is turned into a
// day number from 1970-01-01. If it lies before the cutoff register, the shift
// register is added and the day number goes back to year, month and day.
// Channels: a transaction is taken at a rising edge with start high and busy
// low; busy stays low, so one date can be taken every cycle. The result shows
// for one cycle with done high; the receiver cannot hold it off.
// Pipeline: a date passes through the input register, day number stage, year
// estimate stage, calendar split stage and output register. Throughput: one
// date per cycle; the constant reciprocal multiplies set the stage split.
// Configuration: cfg_index 0 is the cutoff day number, 1 the shift in days;
// other indexes are ignored. cfg_ready is always high. Write only while idle.
// Reset: clears the pipeline valid bits and loads the cutoff with 2019-04-06
// and the shift with 1024 weeks.
`default_nettype none

module gps_week_rollover_date_fix (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [6:0]  year_in_century,
	input  wire logic [3:0]  month_in,
	input  wire logic [4:0]  day_in,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic [11:0]      year_out,
	output logic [3:0]       month_out,
	output logic [4:0]       day_out,
	output logic             was_shifted,
	output logic [24:0]      date_code
);
	import gwr_pkg::*;

	logic [15:0] cutoff_q;
	logic [13:0] shift_q;
	logic        valid_s1;
	logic [6:0]  yic_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic        valid_s2;
	day_num_t    num_s2;
	logic        valid_s4;
	logic        shifted_s4;
	date_t       date_s4;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Load configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
			shift_q <= SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CUTOFF: cutoff_q <= cfg_data;
				REG_SHIFT:  shift_q <= cfg_data[13:0];
				default:    ;
			endcase
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			yic_s1 <= year_in_century;
			month_s1 <= month_in;
			day_s1 <= day_in;
		end
	end

	gwr_days u_days (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.yic_s1   (yic_s1),
		.month_s1 (month_s1),
		.day_s1   (day_s1),
		.cutoff_q (cutoff_q),
		.shift_q  (shift_q),
		.valid_s2 (valid_s2),
		.num_s2   (num_s2)
	);

	gwr_civil u_civil (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.num_s2     (num_s2),
		.valid_s4   (valid_s4),
		.shifted_s4 (shifted_s4),
		.date_s4    (date_s4)
	);

	gwr_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s4    (valid_s4),
		.shifted_s4  (shifted_s4),
		.date_s4     (date_s4),
		.done        (done),
		.year_out    (year_out),
		.month_out   (month_out),
		.day_out     (day_out),
		.was_shifted (was_shifted),
		.date_code   (date_code)
	);

endmodule

`default_nettype wire

// ----- src/gwr_days.sv -----
`default_nettype none

module gwr_days (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire logic [6:0]       yic_s1,
	input  wire logic [3:0]       month_s1,
	input  wire logic [4:0]       day_s1,
	input  wire logic [15:0]      cutoff_q,
	input  wire logic [13:0]      shift_q,
	output logic                  valid_s2,
	output gwr_pkg::day_num_t     num_s2
);
	import gwr_pkg::*;

	logic signed [8:0]  y_adj;
	logic signed [17:0] yterm;
	logic [3:0]         mp;
	logic signed [17:0] sum;
	logic [15:0]        days;
	logic [16:0]        z;
	day_num_t           num_d;

	// Convert the civil date to a day number, compare and add the shift
	always_comb begin
		y_adj = $signed({2'b00, yic_s1}) - ((month_s1 <= 4'd2) ? 9'sd1 : 9'sd0);
		if (y_adj < 0) begin
			yterm = -18'sd366;
		end else begin
			yterm = $signed({2'b00, year_start(y_adj[7:0])});
		end
		mp = (month_s1 > 4'd2) ? (month_s1 - 4'd3) : (month_s1 + 4'd9);
		sum = yterm + $signed({2'b00, MAR_2000_DAY}) + $signed({9'd0, month_offset(mp)})
			+ $signed({13'd0, day_s1}) - 18'sd1;
		days = sum[15:0];
		z = {1'b0, days} + {3'd0, shift_q};
		num_d.shifted = (days < cutoff_q);
		num_d.w = $signed({1'b0, z}) - $signed({2'b00, MAR_2000_DAY});
		num_d.raw.year = BASE_YEAR + {5'd0, yic_s1};
		num_d.raw.month = month_s1;
		num_d.raw.day = day_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s2 <= num_d;
	end

endmodule

`default_nettype wire

// ----- src/gwr_civil.sv -----
`default_nettype none

module gwr_civil (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s2,
	input  wire gwr_pkg::day_num_t num_s2,
	output logic                   valid_s4,
	output logic                   shifted_s4,
	output gwr_pkg::date_t         date_s4
);
	import gwr_pkg::*;

	logic [15:0]       wn2;
	logic [27:0]       prod;
	logic              valid_s3;
	day_num_t          num_s3;
	logic [7:0]        e0_s3;

	logic [15:0]       wn;
	logic [15:0]       s_lo;
	logic [15:0]       s_mid;
	logic [15:0]       s_hi;
	logic [15:0]       diff;
	logic signed [17:0] wneg;
	logic signed [8:0] yoe;
	logic [8:0]        doy;
	logic [3:0]        mp;
	logic [8:0]        dom;
	logic [3:0]        mon;
	date_t             date_d;

	// Estimate the year of the era from the day count
	always_comb begin
		wn2 = num_s2.w[17] ? 16'd0 : num_s2.w[15:0];
		prod = {12'd0, wn2} * {16'd0, YEAR_RECIP};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		num_s3 <= num_s2;
		e0_s3 <= prod[RECIP_SHIFT +: 8];
	end

	// Correct the estimate by one year, then split the day of year into month and day
	always_comb begin
		wn = num_s3.w[15:0];
		s_lo = year_start(e0_s3 - 8'd1);
		s_mid = year_start(e0_s3);
		s_hi = year_start(e0_s3 + 8'd1);
		wneg = num_s3.w + 18'sd366;
		priority if (num_s3.w[17]) begin
			// last year of the previous era: March 1999 to February 2000
			yoe = -9'sd1;
			diff = wneg[15:0];
		end else if (wn < s_mid) begin
			yoe = $signed({1'b0, e0_s3 - 8'd1});
			diff = wn - s_lo;
		end else if (wn >= s_hi) begin
			yoe = $signed({1'b0, e0_s3 + 8'd1});
			diff = wn - s_hi;
		end else begin
			yoe = $signed({1'b0, e0_s3});
			diff = wn - s_mid;
		end
		doy = diff[8:0];

		mp = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy >= month_offset(4'(k))) begin
				mp = 4'(k);
			end
		end
		dom = doy - month_offset(mp);
		mon = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);

		date_d.month = mon;
		date_d.day = dom[4:0] + 5'd1;
		date_d.year = BASE_YEAR + {{3{yoe[8]}}, yoe} + ((mon <= 4'd2) ? 12'd1 : 12'd0);
		if (!num_s3.shifted) begin
			date_d = num_s3.raw;
		end
	end

	always_ff @(posedge clk) begin
		shifted_s4 <= num_s3.shifted;
		date_s4 <= date_d;
	end

endmodule

`default_nettype wire

// ----- src/gwr_pack.sv -----
`default_nettype none

module gwr_pack (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_s4,
	input  wire logic           shifted_s4,
	input  wire gwr_pkg::date_t date_s4,
	output logic                done,
	output logic [11:0]         year_out,
	output logic [3:0]          month_out,
	output logic [4:0]          day_out,
	output logic                was_shifted,
	output logic [24:0]         date_code
);
	import gwr_pkg::*;

	logic [24:0] code_d;

	// Pack the date as decimal YYYYMMDD
	always_comb begin
		code_d = {13'd0, date_s4.year} * 25'd10000 + {21'd0, date_s4.month} * 25'd100
			+ {20'd0, date_s4.day};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		year_out <= date_s4.year;
		month_out <= date_s4.month;
		day_out <= date_s4.day;
		was_shifted <= shifted_s4;
		date_code <= code_d;
	end

endmodule

`default_nettype wire

// ----- src/gwr_checker.sv -----
`default_nettype none

module gwr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [6:0]  year_in_century,
	input wire logic [3:0]  month_in,
	input wire logic [4:0]  day_in,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [1:0]  cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic        done,
	input wire logic [11:0] year_out,
	input wire logic [3:0]  month_out,
	input wire logic [4:0]  day_out,
	input wire logic        was_shifted,
	input wire logic [24:0] date_code
);

	// Every accepted transaction gives exactly one result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted date produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##5 !done)
		else $error("result without an accepted date");

	// A shifted result is a valid calendar date
	a_shifted_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_shifted) |-> (month_out >= 4'd1 && month_out <= 4'd12
			&& day_out >= 5'd1 && day_out <= 5'd31))
		else $error("shifted result is not a calendar date");

	// The packed code agrees with the separate fields
	a_code_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (date_code == ({13'd0, year_out} * 25'd10000
			+ {21'd0, month_out} * 25'd100 + {20'd0, day_out})))
		else $error("date code does not match year, month and day");

endmodule

bind gps_week_rollover_date_fix gwr_checker u_gwr_checker (.*);

`default_nettype wire
